@@ hw/rtl/demand_tile_map_allocator_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the tile map allocator
// Concurrent checks clocked on clk, with and without the reset qualifier.
// ---------------------------------------------------------------------------
`ifndef DEMAND_TILE_MAP_ALLOCATOR_MACROS_SVH
`define DEMAND_TILE_MAP_ALLOCATOR_MACROS_SVH

// Check that is ignored while rst_n is low.
`define DTMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that holds at every edge, reset included.
`define DTMA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/dtma_pkg.sv @@
// ---------------------------------------------------------------------------
// dtma_pkg
// Shared constants and types of the tile map allocator.
// ---------------------------------------------------------------------------
package dtma_pkg;

  // Field widths of the request and result items.
  localparam int COORD_W    = 11;
  localparam int PATCH_W    = 12;
  localparam int OFS_W      = 5;
  localparam int TILE_SHIFT = 5;

  // Number of distinct tile coordinates a raster coordinate can reach.
  localparam int COARSE_N   = 2 ** (COORD_W - TILE_SHIFT);

  // Default tile grid.
  localparam int DEF_TILE_COLS = 64;
  localparam int DEF_TILE_ROWS = 64;

  // Operation codes.
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // One entry of the tile map memory.
  typedef struct packed {
    logic               valid;
    logic [PATCH_W-1:0] patch;
  } map_entry_t;

endpackage

@@ hw/rtl/demand_tile_map_allocator.sv @@
// ---------------------------------------------------------------------------
// demand_tile_map_allocator
// Maps raster points to tile patches and hands out patches on first touch.
//
//   channel   | handshake          | payload
//   ----------+--------------------+----------------------------------------
//   request   | start / busy       | in_op, in_x, in_y
//   result    | out_valid (strobe) | out_patch_index, out_word_offset,
//             |                    | out_fresh
//
// Lookups are taken one per cycle while busy is low; each result strobes
// after its item passes the read stage and the result registers. The map
// memory read is registered and the allocate write follows in the next
// cycle, with a bypass for back-to-back same tiles. A clear item holds busy
// while the memory is swept one entry per cycle; reset runs the same pass.
// The receiver takes every result; nothing on the output side stalls.
// ---------------------------------------------------------------------------
module demand_tile_map_allocator #(
  parameter int TILE_COLS = dtma_pkg::DEF_TILE_COLS,
  parameter int TILE_ROWS = dtma_pkg::DEF_TILE_ROWS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_op,
  input  logic [dtma_pkg::COORD_W-1:0]  in_x,
  input  logic [dtma_pkg::COORD_W-1:0]  in_y,
  output logic                          out_valid,
  output logic [dtma_pkg::PATCH_W-1:0]  out_patch_index,
  output logic [dtma_pkg::OFS_W-1:0]    out_word_offset,
  output logic                          out_fresh
);

`include "demand_tile_map_allocator_macros.svh"

  localparam int NUM_TILES = TILE_COLS * TILE_ROWS;
  localparam int ADDR_W    = (NUM_TILES > 1) ? $clog2(NUM_TILES) : 1;
  localparam int NF_W      = $clog2(NUM_TILES + 1);
  localparam int PATCH_W   = dtma_pkg::PATCH_W;

  // Sweep and pool state.
  logic                 sweep_r;
  logic [ADDR_W-1:0]    sweep_addr_r;
  logic [ADDR_W-1:0]    sweep_addr_nxt;
  logic [NF_W-1:0]      next_free_r;
  logic [NF_W-1:0]      next_free_nxt;

  // Item in the memory read stage.
  logic                 s1_vld_r;
  logic                 s1_clr_r;
  logic [ADDR_W-1:0]    s1_addr_r;
  logic [dtma_pkg::OFS_W-1:0] s1_ofs_r;

  // Write bypass for a read that overlapped the previous allocate.
  logic                 fwd_r;
  dtma_pkg::map_entry_t fwd_data_r;

  // Result registers.
  logic                 out_valid_r;
  logic [PATCH_W-1:0]   out_patch_r;
  logic [dtma_pkg::OFS_W-1:0] out_ofs_r;
  logic                 out_fresh_r;

  logic                 accept;
  logic [ADDR_W-1:0]    tile;
  dtma_pkg::map_entry_t rd_data;
  dtma_pkg::map_entry_t cur_entry;
  dtma_pkg::map_entry_t alloc_entry;
  logic                 s1_alloc;
  logic                 pool_left;
  logic [NF_W-1:0]      pool_sel;
  logic [NF_W+PATCH_W-1:0] pool_ext;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  dtma_pkg::map_entry_t wr_data;

  assign accept = start && !sweep_r;
  assign busy   = sweep_r;

  dtma_tile_index #(
    .TILE_COLS (TILE_COLS),
    .TILE_ROWS (TILE_ROWS),
    .ADDR_W    (ADDR_W)
  ) u_index (
    .x    (in_x),
    .y    (in_y),
    .tile (tile)
  );

  // Entry seen by the item in the read stage, bypassed when needed.
  assign cur_entry = fwd_r ? fwd_data_r : rd_data;
  assign s1_alloc  = s1_vld_r && !s1_clr_r && !cur_entry.valid;

  // Next patch of the pool; the last one is reused if the pool runs dry.
  assign pool_left = next_free_r < NF_W'(NUM_TILES);
  assign pool_sel  = pool_left ? next_free_r : NF_W'(NUM_TILES - 1);
  assign pool_ext  = {{PATCH_W{1'b0}}, pool_sel};
  assign alloc_entry.valid = 1'b1;
  assign alloc_entry.patch = pool_ext[PATCH_W-1:0];

  // Memory write: sweep entries while clearing, else record allocations.
  always_comb begin
    if (sweep_r) begin
      wr_en   = 1'b1;
      wr_addr = sweep_addr_r;
      wr_data = '0;
    end else begin
      wr_en   = s1_alloc;
      wr_addr = s1_addr_r;
      wr_data = alloc_entry;
    end
  end

  dtma_map_ram #(
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (tile),
    .rd_data (rd_data)
  );

  // Pool pointer: reset by a clear, advanced by each allocation.
  always_comb begin
    next_free_nxt = next_free_r;
    if (s1_vld_r && s1_clr_r) begin
      next_free_nxt = '0;
    end else if (s1_alloc && pool_left) begin
      next_free_nxt = next_free_r + NF_W'(1);
    end
  end

  assign sweep_addr_nxt = sweep_addr_r + ADDR_W'(1);

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r      <= 1'b1;
      sweep_addr_r <= '0;
      next_free_r  <= '0;
      s1_vld_r     <= 1'b0;
      fwd_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      next_free_r <= next_free_nxt;
      s1_vld_r    <= accept;
      out_valid_r <= s1_vld_r;
      fwd_r       <= accept && (in_op == dtma_pkg::OP_LOOKUP) && s1_alloc &&
                     (s1_addr_r == tile);
      if (accept && (in_op == dtma_pkg::OP_CLEAR)) begin
        sweep_r      <= 1'b1;
        sweep_addr_r <= '0;
      end else if (sweep_r) begin
        if (sweep_addr_r == ADDR_W'(NUM_TILES - 1)) begin
          sweep_r <= 1'b0;
        end
        sweep_addr_r <= sweep_addr_nxt;
      end
    end
  end

  // Payload registers of the read stage, the bypass and the result.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_clr_r  <= (in_op == dtma_pkg::OP_CLEAR);
      s1_addr_r <= tile;
      s1_ofs_r  <= in_x[dtma_pkg::OFS_W-1:0];
    end
    fwd_data_r <= alloc_entry;
    if (s1_vld_r) begin
      if (s1_clr_r) begin
        out_patch_r <= '0;
        out_ofs_r   <= '0;
        out_fresh_r <= 1'b0;
      end else begin
        out_patch_r <= s1_alloc ? alloc_entry.patch : cur_entry.patch;
        out_ofs_r   <= s1_ofs_r;
        out_fresh_r <= s1_alloc;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_patch_index = out_patch_r;
  assign out_word_offset = out_ofs_r;
  assign out_fresh       = out_fresh_r;

  // Every accepted item strobes a result after the read and result stages.
  `DTMA_ASSERT(a_result_follows, (start && !busy) |=> ##1 out_valid, "item without result")
  // The pool pointer never passes the number of tiles.
  `DTMA_ASSERT(a_pool_bound, next_free_r <= NF_W'(NUM_TILES), "pool pointer overflow")
  // No allocation is made while the memory is being swept.
  `DTMA_ASSERT(a_no_alloc_in_sweep, !(sweep_r && s1_alloc), "allocate during sweep")
  // The bypass is only armed for an item that is in the read stage.
  `DTMA_ASSERT(a_fwd_has_item, fwd_r |-> (s1_vld_r && !s1_clr_r), "stray bypass")

endmodule

@@ hw/rtl/dtma_tile_index.sv @@
// ---------------------------------------------------------------------------
// dtma_tile_index
// Turns a raster point into its tile number, wrapping on the tile grid.
// ---------------------------------------------------------------------------
module dtma_tile_index #(
  parameter int TILE_COLS = dtma_pkg::DEF_TILE_COLS,
  parameter int TILE_ROWS = dtma_pkg::DEF_TILE_ROWS,
  parameter int ADDR_W    = 12
) (
  input  logic [dtma_pkg::COORD_W-1:0] x,
  input  logic [dtma_pkg::COORD_W-1:0] y,
  output logic [ADDR_W-1:0]            tile
);

  localparam int CRS_W  = dtma_pkg::COORD_W - dtma_pkg::TILE_SHIFT;
  localparam int COL_W  = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;
  localparam int ROW_W  = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
  localparam int PROD_W = ADDR_W + 1;

  logic [COL_W-1:0]  col_lut [dtma_pkg::COARSE_N];
  logic [ROW_W-1:0]  row_lut [dtma_pkg::COARSE_N];
  logic [CRS_W-1:0]  x_crs;
  logic [CRS_W-1:0]  y_crs;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [PROD_W-1:0] sum;

  // Constant tables for the wrap of the tile column and row.
  for (genvar i = 0; i < dtma_pkg::COARSE_N; i++) begin : g_lut
    assign col_lut[i] = COL_W'(i % TILE_COLS);
    assign row_lut[i] = ROW_W'(i % TILE_ROWS);
  end

  assign x_crs = x[dtma_pkg::COORD_W-1:dtma_pkg::TILE_SHIFT];
  assign y_crs = y[dtma_pkg::COORD_W-1:dtma_pkg::TILE_SHIFT];
  assign col   = col_lut[x_crs];
  assign row   = row_lut[y_crs];

  // Tiles are numbered column-major: row + rows * column.
  assign sum  = PROD_W'(row) + PROD_W'(TILE_ROWS) * PROD_W'(col);
  assign tile = sum[ADDR_W-1:0];

endmodule

@@ hw/rtl/dtma_map_ram.sv @@
// ---------------------------------------------------------------------------
// dtma_map_ram
// Tile map memory: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module dtma_map_ram #(
  parameter int ADDR_W = 12
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  dtma_pkg::map_entry_t wr_data,
  input  logic [ADDR_W-1:0]    rd_addr,
  output dtma_pkg::map_entry_t rd_data
);

  localparam int DEPTH = 2 ** ADDR_W;

  dtma_pkg::map_entry_t mem [DEPTH];
  dtma_pkg::map_entry_t rd_data_r;

  // Read returns the old contents when the same entry is written.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
